// ===== hdl/first_fit_block_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared assertion forms; compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge out of reset.
`define FBA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next edge.
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/fba_pkg.sv =====
// ---------------------------------------------------------------------------
// First-fit block allocator package
// Types, codes and default constants shared by the allocator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int ALIGN_BYTES_DEF  = 16;

    // Block offsets carry one spare bit above the 32-bit port width.
    localparam int START_W = 33;
    localparam int DATA_W  = 32;

    localparam logic [DATA_W-1:0] INIT_PAYLOAD_RST = 32'd1048512;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOFIT       = 2'd1,
        ST_BAD_ADDR    = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] request_bytes;
        logic [DATA_W-1:0] freed_address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] granted_address;
        logic [DATA_W-1:0] used_total;
        logic [DATA_W-1:0] capacity_total;
    } t_rsp;

    typedef struct packed {
        logic               is_free;
        logic [START_W-1:0] start;
        logic [DATA_W-1:0]  payload;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SRD,
        S_SCHK,
        S_IRD,
        S_IWR,
        S_MRD,
        S_MCHK,
        S_CRD,
        S_CWR,
        S_FIN_NEW,
        S_FIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/fba_table.sv =====
// ---------------------------------------------------------------------------
// Block table memory
// Simple dual-port synchronous RAM holding one block entry per row.
// ---------------------------------------------------------------------------
`default_nettype none

module fba_table #(
    parameter int DEPTH = fba_pkg::MAX_BLOCKS_DEF,
    parameter int IW    = $clog2(fba_pkg::MAX_BLOCKS_DEF)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IW-1:0]   i_waddr,
    input  wire fba_pkg::t_entry i_wdata,
    input  wire logic [IW-1:0]   i_raddr,
    output fba_pkg::t_entry      o_rdata
);

    fba_pkg::t_entry r_mem [DEPTH];
    fba_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/first_fit_block_allocator.sv =====
// ---------------------------------------------------------------------------
// First-fit block allocator
// Address-ordered block table in RAM with first-fit allocate, split,
// and free with forward merge.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        input      i_in_valid/o_in_stall  t_req (cmd, size, address)
//  out       output     o_out_valid/i_out_stall t_rsp (status, address, counts)
//  cfg       input      i_cfg_valid/o_cfg_ready initial payload bytes
//
// One transaction is worked at a time. The table walk reads each entry from
// RAM and then checks it, for up to N entries of N blocks; an insert or a
// merge with its compaction then walks the later entries, before the write
// back and the result. Reset and each config write rewrite the first table
// entry as one free block. The result sits in an output register, so a
// stalled result does not block the next request until it reaches S_DONE.
// ---------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = fba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fba_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = fba_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire fba_pkg::t_req i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output fba_pkg::t_rsp      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [31:0]   i_cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = fba_pkg::START_W;
    localparam int DW = fba_pkg::DATA_W;

    localparam logic [SW-1:0] HDR_S      = SW'(HEADER_BYTES);
    localparam logic [DW-1:0] HDR_D      = DW'(HEADER_BYTES);
    localparam logic [SW:0]   HDR_ALIGN  = (SW+1)'(HEADER_BYTES + ALIGN_BYTES);
    // The user must keep ALIGN_BYTES a power of two; the block does not check it. Rounding is an add and a mask.
    localparam logic [SW-1:0] ALIGN_M1   = SW'(ALIGN_BYTES - 1);
    localparam logic [SW-1:0] ALIGN_MASK = ~ALIGN_M1;
    localparam logic [CW-1:0] CNT_MAX    = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] CNT_ONE    = CW'(1);

    fba_pkg::t_state  r_state, n_state;
    logic [DW-1:0]    r_init;
    logic [CW-1:0]    r_count;
    logic [DW-1:0]    r_used;
    logic [DW-1:0]    r_total;
    fba_pkg::t_cmd    r_cmd;
    logic [SW-1:0]    r_size;
    logic [DW-1:0]    r_faddr;
    logic [IW-1:0]    r_i;
    logic [CW-1:0]    r_j;
    logic [CW-1:0]    r_k;
    logic [CW-1:0]    r_rm;
    fba_pkg::t_entry  r_ent;
    logic [DW-1:0]    r_acc;
    logic             r_split;
    fba_pkg::t_status r_status;
    logic [DW-1:0]    r_grant;
    logic             r_out_valid;
    fba_pkg::t_rsp    r_out;

    logic             w_we;
    logic [IW-1:0]    w_waddr;
    fba_pkg::t_entry  w_wdata;
    logic [IW-1:0]    w_raddr;
    fba_pkg::t_entry  w_rd;

    logic             w_cfg_wr;
    logic             w_in_acc;
    logic [SW-1:0]    w_size;
    logic             w_req_bad;
    logic [CW-1:0]    w_i_ext;
    logic [CW-1:0]    w_i_next;
    logic             w_last;
    logic             w_hit;
    logic             w_can_split;
    logic             w_ins_more;
    logic [CW-1:0]    w_src;
    logic             w_cmp_more;
    logic             w_out_free;
    logic [DW-1:0]    w_fin_payload;

    fba_table #(
        .DEPTH (MAX_BLOCKS),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_size    = ({1'b0, i_in.request_bytes} + ALIGN_M1) & ALIGN_MASK;
    assign w_req_bad = (i_in.request_bytes == '0) || w_size[SW-1];
    assign w_i_ext   = CW'(r_i);
    assign w_i_next  = w_i_ext + CNT_ONE;
    assign w_last    = (w_i_next >= r_count);
    assign w_hit     = (r_cmd == fba_pkg::CMD_ALLOC) ?
                       (w_rd.is_free && ({1'b0, w_rd.payload} >= r_size)) :
                       (w_rd.start == {1'b0, r_faddr});
    assign w_can_split = (r_count < CNT_MAX) &&
                         ({2'b00, w_rd.payload} >= ({1'b0, r_size} + HDR_ALIGN));
    assign w_ins_more  = (r_k > w_i_next);
    assign w_src       = r_k + r_rm;
    assign w_cmp_more  = (r_rm != '0) && (w_src < r_count);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fin_payload = r_split ? r_size[DW-1:0] : r_ent.payload;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fba_pkg::S_INIT: n_state = fba_pkg::S_IDLE;
            fba_pkg::S_IDLE: begin
                if (w_cfg_wr) begin
                    n_state = fba_pkg::S_INIT;
                end else if (w_in_acc) begin
                    if (i_in.cmd == fba_pkg::CMD_ALLOC) begin
                        n_state = w_req_bad ? fba_pkg::S_DONE : fba_pkg::S_SRD;
                    end else begin
                        n_state = (i_in.freed_address == '0) ? fba_pkg::S_DONE
                                                              : fba_pkg::S_SRD;
                    end
                end
            end
            fba_pkg::S_SRD: n_state = fba_pkg::S_SCHK;
            fba_pkg::S_SCHK: begin
                if (w_hit) begin
                    if (r_cmd == fba_pkg::CMD_ALLOC) begin
                        n_state = w_can_split ? fba_pkg::S_IRD : fba_pkg::S_FIN;
                    end else if (w_rd.is_free) begin
                        n_state = fba_pkg::S_DONE;
                    end else begin
                        n_state = w_last ? fba_pkg::S_FIN : fba_pkg::S_MRD;
                    end
                end else begin
                    n_state = w_last ? fba_pkg::S_DONE : fba_pkg::S_SRD;
                end
            end
            fba_pkg::S_IRD:  n_state = w_ins_more ? fba_pkg::S_IWR : fba_pkg::S_FIN_NEW;
            fba_pkg::S_IWR:  n_state = fba_pkg::S_IRD;
            fba_pkg::S_MRD:  n_state = fba_pkg::S_MCHK;
            fba_pkg::S_MCHK: begin
                if (w_rd.is_free && ((r_j + CNT_ONE) < r_count)) begin
                    n_state = fba_pkg::S_MRD;
                end else begin
                    n_state = fba_pkg::S_CRD;
                end
            end
            fba_pkg::S_CRD:     n_state = w_cmp_more ? fba_pkg::S_CWR : fba_pkg::S_FIN;
            fba_pkg::S_CWR:     n_state = fba_pkg::S_CRD;
            fba_pkg::S_FIN_NEW: n_state = fba_pkg::S_FIN;
            fba_pkg::S_FIN:     n_state = fba_pkg::S_DONE;
            fba_pkg::S_DONE:    n_state = w_out_free ? fba_pkg::S_IDLE : fba_pkg::S_DONE;
            default:            n_state = fba_pkg::S_INIT;
        endcase
    end

    // Table port and handshake outputs.
    always_comb begin
        w_we        = 1'b0;
        w_waddr     = r_i;
        w_wdata     = r_ent;
        w_raddr     = r_i;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            fba_pkg::S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{is_free: 1'b1, start: HDR_S, payload: r_init};
            end
            fba_pkg::S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_in_stall  = i_cfg_valid;
            end
            fba_pkg::S_IRD: w_raddr = IW'(r_k - CNT_ONE);
            fba_pkg::S_IWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0];
                w_wdata = w_rd;
            end
            fba_pkg::S_MRD: w_raddr = r_j[IW-1:0];
            fba_pkg::S_CRD: w_raddr = w_src[IW-1:0];
            fba_pkg::S_CWR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0];
                w_wdata = w_rd;
            end
            fba_pkg::S_FIN_NEW: begin
                w_we    = 1'b1;
                w_waddr = w_i_next[IW-1:0];
                w_wdata = '{is_free: 1'b1,
                            start:   r_ent.start + r_size + HDR_S,
                            payload: r_ent.payload - r_size[DW-1:0] - HDR_D};
            end
            fba_pkg::S_FIN: begin
                w_we = 1'b1;
                if (r_cmd == fba_pkg::CMD_ALLOC) begin
                    w_wdata = '{is_free: 1'b0, start: r_ent.start, payload: w_fin_payload};
                end else begin
                    w_wdata = '{is_free: 1'b1, start: r_ent.start, payload: r_acc};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fba_pkg::S_INIT;
            r_init      <= fba_pkg::INIT_PAYLOAD_RST;
            r_count     <= CNT_ONE;
            r_used      <= '0;
            r_total     <= fba_pkg::INIT_PAYLOAD_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == fba_pkg::S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                fba_pkg::S_IDLE: begin
                    if (w_cfg_wr) begin
                        r_init  <= i_cfg_data;
                        r_count <= CNT_ONE;
                        r_used  <= '0;
                        r_total <= i_cfg_data;
                    end else if (w_in_acc) begin
                        r_cmd    <= i_in.cmd;
                        r_size   <= w_size;
                        r_faddr  <= i_in.freed_address;
                        r_i      <= '0;
                        r_grant  <= '0;
                        r_status <= (i_in.cmd == fba_pkg::CMD_ALLOC && w_req_bad) ?
                                    fba_pkg::ST_NOFIT : fba_pkg::ST_OK;
                    end
                end
                fba_pkg::S_SCHK: begin
                    r_ent   <= w_rd;
                    r_split <= w_can_split;
                    r_k     <= (r_cmd == fba_pkg::CMD_ALLOC) ? r_count : w_i_next;
                    r_j     <= w_i_next;
                    r_acc   <= w_rd.payload;
                    r_rm    <= '0;
                    if (w_hit) begin
                        if (r_cmd == fba_pkg::CMD_FREE && w_rd.is_free) begin
                            r_status <= fba_pkg::ST_DOUBLE_FREE;
                        end
                    end else if (w_last) begin
                        r_status <= (r_cmd == fba_pkg::CMD_ALLOC) ?
                                    fba_pkg::ST_NOFIT : fba_pkg::ST_BAD_ADDR;
                    end else begin
                        r_i <= w_i_next[IW-1:0];
                    end
                end
                fba_pkg::S_IWR: r_k <= r_k - CNT_ONE;
                fba_pkg::S_MCHK: begin
                    if (w_rd.is_free) begin
                        r_acc   <= r_acc + HDR_D + w_rd.payload;
                        r_total <= r_total + HDR_D;
                        r_rm    <= r_rm + CNT_ONE;
                        r_j     <= r_j + CNT_ONE;
                    end
                end
                fba_pkg::S_CWR: r_k <= r_k + CNT_ONE;
                fba_pkg::S_FIN: begin
                    if (r_cmd == fba_pkg::CMD_ALLOC) begin
                        r_used  <= r_used + w_fin_payload;
                        r_grant <= r_ent.start[DW-1:0];
                        if (r_split) begin
                            r_count <= r_count + CNT_ONE;
                            r_total <= r_total - HDR_D;
                        end
                    end else begin
                        r_used  <= r_used - r_ent.payload;
                        r_count <= r_count - r_rm;
                    end
                end
                fba_pkg::S_DONE: begin
                    if (w_out_free) begin
                        r_out <= '{status:          r_status,
                                   granted_address: r_grant,
                                   used_total:      r_used,
                                   capacity_total:  r_total};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `FBA_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, (r_count != '0) && (r_count <= CNT_MAX), "block count out of range")
    `FBA_ASSERT_ALWAYS(a_used_le_total, i_clk, i_rst_n, r_used <= r_total, "used bytes exceed capacity")
    `FBA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != fba_pkg::S_IDLE, "accepted request did not start")
    `FBA_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, (r_state == fba_pkg::S_DONE) && r_out_valid && i_out_stall, r_state == fba_pkg::S_DONE, "result dropped while output stalled")

endmodule

`default_nettype wire
